// ===== hw/rtl/ltsd_pkg.sv =====
// ---------------------------------------------------------------------------
// ltsd_pkg
// Shared types, codes and helpers of the LZ token stream decompressor.
// ---------------------------------------------------------------------------
package ltsd_pkg;

   // parser position within one sequence
   typedef enum logic [2:0] {
      PH_TOKEN,
      PH_LITEXT,
      PH_MATCHEXT,
      PH_DISTLO,
      PH_DISTHI,
      PH_LITERALS,
      PH_COPY
   } phase_type;

   // status codes
   localparam logic [2:0] ST_RUN   = 3'd0;
   localparam logic [2:0] ST_DONE  = 3'd1;
   localparam logic [2:0] ST_TRUNC = 3'd2;
   localparam logic [2:0] ST_DIST  = 3'd3;
   localparam logic [2:0] ST_OVER  = 3'd4;

   localparam logic [7:0]  EXT_CONTINUE  = 8'd255;
   localparam logic [2:0]  LIT_LEN_EXT   = 3'd7;
   localparam logic [3:0]  MATCH_LEN_EXT = 4'd15;
   localparam logic [31:0] MATCH_MIN     = 32'd4;
   localparam logic [15:0] END_DISTANCE  = 16'hFFFF;

   // one result word towards the response queue
   typedef struct packed {
      logic [31:0] match_left;
      logic [2:0]  status;
      logic [7:0]  out_byte;
      logic        out_valid;
   } rsp_item_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

// ===== hw/rtl/ltsd_ram.sv =====
// ---------------------------------------------------------------------------
// ltsd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ltsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ltsd_resp_fifo.sv =====
// ---------------------------------------------------------------------------
// ltsd_resp_fifo
// Four-entry response queue between the parser and the result channel.
// ---------------------------------------------------------------------------
module ltsd_resp_fifo
   import ltsd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  rsp_item_type push_item,
   input  logic         pop_ready,
   output logic         pop_valid,
   output rsp_item_type pop_item,
   output logic [2:0]   count
);

   rsp_item_type entries_ff [4];
   logic [1:0]   wr_ptr_ff, wr_ptr_in;
   logic [1:0]   rd_ptr_ff, rd_ptr_in;
   logic [2:0]   count_ff, count_in;
   logic         pop_fire;

   assign pop_valid = (count_ff != 3'd0);
   assign pop_fire  = pop_valid && pop_ready;
   assign pop_item  = entries_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = pop_fire ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + {2'b00, push_valid} - {2'b00, pop_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   // the upstream credit check must never let a word land on a full queue
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push_valid && count_ff == 3'd4))
      else $error("response queue overrun");

endmodule

// ===== hw/rtl/ltsd_parser.sv =====
// ---------------------------------------------------------------------------
// ltsd_parser
// Token parser and copy engine: updates the sequence state for each word,
// drives the history RAM and assembles one response word the next cycle.
// ---------------------------------------------------------------------------
module ltsd_parser
   import ltsd_pkg::*;
#(
   parameter int HISTORY_DEPTH = 65536,
   localparam int HistAw = $clog2(HISTORY_DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_accept,
   input  logic              in_mode,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   input  logic [31:0]       max_len,
   output logic [HistAw-1:0] ram_rd_addr,
   input  logic [7:0]        ram_rd_data,
   output logic              ram_wr_en,
   output logic [HistAw-1:0] ram_wr_addr,
   output logic [7:0]        ram_wr_data,
   output logic              s1_valid,
   output rsp_item_type      s1_item
);

   phase_type   phase_ff, phase_in;
   logic [31:0] lit_ff, lit_in;
   logic [31:0] match_ff, match_in;
   logic [15:0] dist_ff, dist_in;
   logic        long_ff, long_in;
   logic [31:0] count_ff, count_in;
   logic [2:0]  status_ff, status_in;

   logic        run;
   logic        room;
   logic [15:0] dist_cand;
   logic        dist_before;
   logic        end_cand;
   logic        emit;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_emit_ff, s1_emit_in;
   logic              s1_copy_ff, s1_copy_in;
   logic [7:0]        s1_lit_ff, s1_lit_in;
   logic [2:0]        s1_status_ff, s1_status_in;
   logic [31:0]       s1_match_ff, s1_match_in;
   logic [HistAw-1:0] s1_waddr_ff, s1_waddr_in;
   logic              s1_fwd_ff, s1_fwd_in;
   logic [7:0]        s1_fwd_data_ff, s1_fwd_data_in;
   logic [7:0]        s1_byte;

   assign run         = (status_ff == ST_RUN);
   assign room        = (count_ff < max_len);
   assign dist_cand   = (phase_ff == PH_DISTHI) ? {in_byte, dist_ff[7:0]} : {8'h00, in_byte};
   assign dist_before = (count_ff <= {16'h0000, dist_cand});
   assign end_cand    = long_ff && (dist_cand == END_DISTANCE);

   // next state of the sequence registers
   always_comb begin
      phase_in  = phase_ff;
      lit_in    = lit_ff;
      match_in  = match_ff;
      dist_in   = dist_ff;
      long_in   = long_ff;
      count_in  = count_ff;
      status_in = status_ff;
      if (in_accept && run) begin
         if (in_mode) begin
            if (phase_ff == PH_COPY && match_ff != 32'd0) begin
               if (room) begin
                  count_in = count_ff + 32'd1;
                  match_in = match_ff - 32'd1;
                  if (match_ff == 32'd1) begin
                     phase_in = PH_TOKEN;
                  end
               end else begin
                  status_in = ST_OVER;
                  lit_in    = 32'd0;
                  match_in  = 32'd0;
               end
            end
         end else if (phase_ff != PH_COPY) begin
            case (phase_ff)
               PH_TOKEN: begin
                  lit_in   = {29'd0, in_byte[7:5]};
                  match_in = {28'd0, in_byte[3:0]};
                  long_in  = in_byte[4];
                  dist_in  = 16'h0000;
                  if (in_byte[7:5] == LIT_LEN_EXT) begin
                     phase_in = PH_LITEXT;
                  end else if (in_byte[3:0] == MATCH_LEN_EXT) begin
                     phase_in = PH_MATCHEXT;
                  end else begin
                     phase_in = PH_DISTLO;
                  end
               end
               PH_LITEXT: begin
                  lit_in = sat_add(lit_ff, {24'd0, in_byte});
                  if (in_byte != EXT_CONTINUE) begin
                     phase_in = (match_ff == {28'd0, MATCH_LEN_EXT}) ? PH_MATCHEXT : PH_DISTLO;
                  end
               end
               PH_MATCHEXT: begin
                  match_in = sat_add(match_ff, {24'd0, in_byte});
                  if (in_byte != EXT_CONTINUE) begin
                     phase_in = PH_DISTLO;
                  end
               end
               PH_DISTLO, PH_DISTHI: begin
                  dist_in = dist_cand;
                  if (phase_ff == PH_DISTLO && long_ff) begin
                     phase_in = PH_DISTHI;
                  end else if (lit_ff != 32'd0) begin
                     phase_in = PH_LITERALS;
                  end else if (end_cand) begin
                     status_in = ST_DONE;
                     lit_in    = 32'd0;
                     match_in  = 32'd0;
                  end else if (dist_before) begin
                     status_in = ST_DIST;
                     lit_in    = 32'd0;
                     match_in  = 32'd0;
                  end else begin
                     match_in = sat_add(match_ff, MATCH_MIN);
                     phase_in = PH_COPY;
                  end
               end
               PH_LITERALS: begin
                  if (room) begin
                     count_in = count_ff + 32'd1;
                     lit_in   = lit_ff - 32'd1;
                     if (lit_ff == 32'd1) begin
                        if (long_ff && dist_ff == END_DISTANCE) begin
                           status_in = ST_DONE;
                           match_in  = 32'd0;
                        end else if (count_ff < {16'h0000, dist_ff}) begin
                           status_in = ST_DIST;
                           match_in  = 32'd0;
                        end else begin
                           match_in = sat_add(match_ff, MATCH_MIN);
                           phase_in = PH_COPY;
                        end
                     end
                  end else begin
                     status_in = ST_OVER;
                     lit_in    = 32'd0;
                     match_in  = 32'd0;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
            if (in_last && status_in == ST_RUN) begin
               status_in = ST_TRUNC;
               lit_in    = 32'd0;
               match_in  = 32'd0;
            end
         end
      end
   end

   // history access and response capture
   always_comb begin
      emit = in_accept && run && room &&
             ((in_mode && phase_ff == PH_COPY && match_ff != 32'd0) ||
              (!in_mode && phase_ff == PH_LITERALS));
      ram_rd_addr    = HistAw'(count_ff - {16'h0000, dist_ff} - 32'd1);
      s1_valid_in    = in_accept;
      s1_emit_in     = emit;
      s1_copy_in     = in_mode;
      s1_lit_in      = in_byte;
      s1_status_in   = status_in;
      s1_match_in    = match_in;
      s1_waddr_in    = count_ff[HistAw-1:0];
      s1_fwd_in      = ram_wr_en && (ram_wr_addr == ram_rd_addr);
      s1_fwd_data_in = s1_byte;
   end

   always_comb begin
      if (!s1_emit_ff) begin
         s1_byte = 8'h00;
      end else if (s1_copy_ff) begin
         s1_byte = s1_fwd_ff ? s1_fwd_data_ff : ram_rd_data;
      end else begin
         s1_byte = s1_lit_ff;
      end
      ram_wr_en   = s1_valid_ff && s1_emit_ff;
      ram_wr_addr = s1_waddr_ff;
      ram_wr_data = s1_byte;
   end

   assign s1_valid           = s1_valid_ff;
   assign s1_item.out_valid  = s1_emit_ff;
   assign s1_item.out_byte   = s1_byte;
   assign s1_item.status     = s1_status_ff;
   assign s1_item.match_left = s1_match_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_TOKEN;
         lit_ff      <= 32'd0;
         match_ff    <= 32'd0;
         dist_ff     <= 16'h0000;
         long_ff     <= 1'b0;
         count_ff    <= 32'd0;
         status_ff   <= ST_RUN;
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         lit_ff      <= lit_in;
         match_ff    <= match_in;
         dist_ff     <= dist_in;
         long_ff     <= long_in;
         count_ff    <= count_in;
         status_ff   <= status_in;
         s1_valid_ff <= s1_valid_in;
         s1_emit_ff  <= s1_emit_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_copy_ff     <= s1_copy_in;
      s1_lit_ff      <= s1_lit_in;
      s1_status_ff   <= s1_status_in;
      s1_match_ff    <= s1_match_in;
      s1_waddr_ff    <= s1_waddr_in;
      s1_fwd_ff      <= s1_fwd_in;
      s1_fwd_data_ff <= s1_fwd_data_in;
   end

   a_status_sticky: assert property (@(posedge clock) disable iff (reset)
      (status_ff != ST_RUN) |=> (status_ff == $past(status_ff)))
      else $error("status left a stopped code");

   a_stop_clears_lengths: assert property (@(posedge clock) disable iff (reset)
      (status_ff != ST_RUN) |-> (lit_ff == 32'd0 && match_ff == 32'd0))
      else $error("lengths pending after stop");

   a_copy_has_work: assert property (@(posedge clock) disable iff (reset)
      (status_ff == ST_RUN && phase_ff == PH_COPY) |-> (match_ff != 32'd0))
      else $error("copy phase with nothing to copy");

endmodule

// ===== hw/rtl/lz_token_stream_decompressor.sv =====
// ---------------------------------------------------------------------------
// lz_token_stream_decompressor
// Streaming LZ77 token decompressor with a 64 KiB history RAM.
// ---------------------------------------------------------------------------
// Feed compressed bytes (req_tuser = 0) and drain ticks (req_tuser = 1) on
// the request stream, one word per clock; every accepted request word gives
// exactly one response word, carrying an optional output byte, the sticky
// status and the match bytes still to copy. Drive one drain tick per
// remaining match byte. The rate is one word per cycle: the history RAM is
// written and read once per cycle, and a copy that reads the byte written
// by the word just before is forwarded around the RAM. req_tready falls
// only when the four-entry response queue and the parser output stage hold
// four words not yet taken. The history is not cleared after reset; a match
// never reaches back before the first byte written, so none is needed.
// Write max_output_len on the csr_ port only while the block is idle.
module lz_token_stream_decompressor
   import ltsd_pkg::*;
#(
   parameter int HISTORY_DEPTH = 65536
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] mode
   input  logic        req_tlast,   // in_last
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] out_byte, [10:8] status, [42:11] match_left
   output logic        rsp_tuser,   // [0] out_valid
   // max_output_len write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   localparam int HistAw = $clog2(HISTORY_DEPTH);

   logic [31:0]       max_len_ff, max_len_in;
   logic              req_fire;
   logic [HistAw-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;
   logic              ram_wr_en;
   logic [HistAw-1:0] ram_wr_addr;
   logic [7:0]        ram_wr_data;
   logic              s1_valid;
   rsp_item_type      s1_item;
   rsp_item_type      rsp_item;
   logic [2:0]        fifo_count;
   logic [2:0]        in_flight;

   // capacity register: always ready; user must write it only while idle, unchecked
   assign csr_ready  = 1'b1;
   assign max_len_in = (csr_valid && csr_ready) ? csr_data : max_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= 32'hFFFF_FFFF;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   // credit check: queued words plus the one in the output stage leave room
   assign in_flight  = fifo_count + {2'b00, s1_valid};
   assign req_tready = !reset && (in_flight <= 3'd3);
   assign req_fire   = req_tvalid && req_tready;

   ltsd_ram #(
      .WIDTH (8),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ltsd_parser #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .in_accept   (req_fire),
      .in_mode     (req_tuser),
      .in_byte     (req_tdata),
      .in_last     (req_tlast),
      .max_len     (max_len_ff),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .s1_valid    (s1_valid),
      .s1_item     (s1_item)
   );

   ltsd_resp_fifo u_resp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (s1_valid),
      .push_item  (s1_item),
      .pop_ready  (rsp_tready),
      .pop_valid  (rsp_tvalid),
      .pop_item   (rsp_item),
      .count      (fifo_count)
   );

   // pack the response word, padded to whole bytes
   assign rsp_tdata = {5'b00000, rsp_item.match_left, rsp_item.status, rsp_item.out_byte};
   assign rsp_tuser = rsp_item.out_valid;

endmodule
